FILE: src/fspa_pkg.sv
// Shared types, constants and the CRC byte update for the framed sensor packet averager.
package fspa_pkg;

  // Frame layout
  localparam int unsigned FRAME_BYTES = 11;
  localparam int unsigned POS_W = 4;
  localparam logic [7:0] HDR_FIRST = 8'h01;
  localparam logic [7:0] HDR_SECOND = 8'h03;
  localparam logic [POS_W-1:0] POS_START = 4'd0;
  localparam logic [POS_W-1:0] POS_HDR = 4'd1;
  localparam logic [POS_W-1:0] POS_TURN_FIRST = 4'd3;
  localparam logic [POS_W-1:0] POS_TURN_LAST = 4'd6;
  localparam logic [POS_W-1:0] POS_AMP_FIRST = 4'd7;
  localparam logic [POS_W-1:0] POS_AMP_LAST = 4'd8;
  localparam logic [POS_W-1:0] POS_CRC_LO = 4'd9;
  localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(FRAME_BYTES - 1);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CURRENT_LIMIT = 16'd3000;

  // Configuration
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SINGLE_TURN_STEPS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_REVOLUTIONS = 8'd1;
  localparam logic [15:0] STEPS_RESET = 16'd4096;
  localparam logic [15:0] REVS_RESET = 16'd64;

  // Report status codes
  localparam logic [1:0] ST_NONE = 2'd0;
  localparam logic [1:0] ST_AVG = 2'd1;
  localparam logic [1:0] ST_HIGH = 2'd2;
  localparam logic [1:0] ST_LOW = 2'd3;

  // Divider sequencing
  localparam int unsigned DIV_CNT_W = 5;
  localparam logic [DIV_CNT_W-1:0] TURN_STEP_LAST = 5'd31;
  localparam logic [DIV_CNT_W-1:0] CUR_STEP_LAST = 5'd15;

  typedef struct packed {
    logic take_byte;   // latch the incoming byte
    logic poll_start;  // snapshot sums, pick status, clear accumulators
    logic step_byte;   // run the frame hunt on the latched byte
    logic classify;    // class a completed frame and accumulate
    logic div_step;    // one restoring divide step
    logic div_swap;    // keep turn quotient, start current divide
    logic load_out;    // move the result into the output register
  } fspa_cmd_t;

  typedef struct packed {
    logic frame_last;  // latched byte is the last byte of a frame
    logic have_avg;    // accepted count is nonzero
  } fspa_stat_t;

  // CRC-16/MODBUS update by one byte, reflected, one bit per step.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: src/framed_sensor_packet_averager.sv
// Top level of the framed sensor packet averager: ports, controller and datapath.
// A byte transfer is accepted, then hunted and folded into the CRC; the last byte of a frame
//   then goes through a check that classifies and accumulates its reading.
// A poll end raises m_axis_tvalid once the output register is free and loaded; with readings
//   accepted, the bit-serial divider runs first (32 turn steps, swap, 16 current steps).
// Reset (rst_ni low, asynchronous) clears frame position, sums, counts, handshake state
//   and restores single_turn_steps to 4096 and max_revolutions to 64.
module framed_sensor_packet_averager
  import fspa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
  input  logic                 s_axis_tuser,   // [0] opcode: 0 byte, 1 poll end
  // Result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [47:0]          m_axis_tdata,   // [31:0] average_full_count, [47:32] average_current
  output logic [1:0]           m_axis_tuser,   // [1:0] report_status
  // Configuration write channel
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i
);

  fspa_cmd_t  cmd;
  fspa_stat_t stat;
  logic [31:0] avg_turns;
  logic [15:0] avg_current;
  logic [1:0]  status;

  // Configuration writes are registered; the port never stalls.
  assign cfg_ready_o = 1'b1;

  // Sequence every transfer: latch, hunt and check a byte; on a poll end, divide if needed
  // and load the output register. The output register lets a new item in while a result waits.
  fspa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_poll_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Hold frame bytes in place, keep the running CRC, accumulate good
  // readings and divide on poll end.
  fspa_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .rx_byte_i     (s_axis_tdata),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .avg_turns_o   (avg_turns),
    .avg_current_o (avg_current),
    .status_o      (status)
  );

  // Pack result fields, first field in the low bits.
  assign m_axis_tdata = {avg_current, avg_turns};
  assign m_axis_tuser = status;

endmodule

FILE: src/fspa_ctrl.sv
// Controller state machine: sequences byte handling, frame check, divide and result load.
module fspa_ctrl
  import fspa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_poll_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  fspa_stat_t stat_i,
  output fspa_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BYTE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIVT  = 3'd3;
  localparam logic [2:0] S_SWAP  = 3'd4;
  localparam logic [2:0] S_DIVC  = 3'd5;
  localparam logic [2:0] S_LOAD  = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_ready_o && in_valid_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_poll_i) begin
            cmd_o.poll_start = 1'b1;
            cnt_d = '0;
            state_d = stat_i.have_avg ? S_DIVT : S_LOAD;
          end else begin
            cmd_o.take_byte = 1'b1;
            state_d = S_BYTE;
          end
        end
      end
      S_BYTE: begin
        cmd_o.step_byte = 1'b1;
        state_d = stat_i.frame_last ? S_CHECK : S_IDLE;
      end
      S_CHECK: begin
        cmd_o.classify = 1'b1;
        state_d = S_IDLE;
      end
      S_DIVT: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == TURN_STEP_LAST) begin
          state_d = S_SWAP;
        end
      end
      S_SWAP: begin
        cmd_o.div_swap = 1'b1;
        cnt_d = '0;
        state_d = S_DIVC;
      end
      S_DIVC: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CUR_STEP_LAST) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        // Wait for the output register to drain before overwriting it
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: src/fspa_datapath.sv
// Datapath: frame hunt, CRC, classification, accumulators, divider and output register.
module fspa_datapath
  import fspa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fspa_cmd_t            cmd_i,
  output fspa_stat_t           stat_o,
  input  logic [7:0]           rx_byte_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]          cfg_data_i,
  output logic [31:0]          avg_turns_o,
  output logic [15:0]          avg_current_o,
  output logic [1:0]           status_o
);

  // Configuration and derived limit
  logic [15:0] steps_q, revs_q;
  logic [31:0] limit_q;

  // Frame assembly
  logic [POS_W-1:0] pos_q;
  logic [7:0]       byte_q;
  logic [15:0]      crc_q;
  logic [31:0]      turns_q;
  logic [15:0]      amps_q;
  logic [7:0]       crc_lo_q;
  logic             crc_ok_q;
  logic [15:0]      crc_next;

  // Accumulators
  logic [31:0] turn_sum_q;
  logic [15:0] cur_sum_q, acc_cnt_q, high_cnt_q, low_cnt_q;
  logic        is_high;

  // Divider
  logic [31:0] quo_q;
  logic [15:0] rem_q, div_q, cur_snap_q, avg_turns_q;
  logic [1:0]  status_q;
  logic [16:0] rem_sh, rem_diff;
  logic        rem_ge;

  // Output register
  logic [31:0] out_turns_q;
  logic [15:0] out_cur_q;
  logic [1:0]  out_status_q;

  assign crc_next = crc_byte((pos_q == POS_START) ? CRC_INIT : crc_q, byte_q);
  assign stat_o.frame_last = (pos_q == POS_CRC_HI);
  assign stat_o.have_avg   = (acc_cnt_q != '0);

  assign is_high  = (turns_q > limit_q) || (amps_q > CURRENT_LIMIT);

  assign rem_sh   = {rem_q, quo_q[31]};
  assign rem_ge   = (rem_sh >= {1'b0, div_q});
  assign rem_diff = rem_sh - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= STEPS_RESET;
      revs_q  <= REVS_RESET;
      limit_q <= 32'(STEPS_RESET) * 32'(REVS_RESET);
    end else begin
      if (cfg_we_i && (cfg_index_i == REG_SINGLE_TURN_STEPS)) begin
        steps_q <= cfg_data_i;
      end
      if (cfg_we_i && (cfg_index_i == REG_MAX_REVOLUTIONS)) begin
        revs_q <= cfg_data_i;
      end
      limit_q <= 32'(steps_q) * 32'(revs_q);
    end
  end

  // Frame hunt on the latched byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_START;
    end else if (cmd_i.step_byte) begin
      priority if (pos_q == POS_START) begin
        if (byte_q == HDR_FIRST) begin
          pos_q <= POS_HDR;
        end
      end else if (pos_q == POS_HDR) begin
        pos_q <= (byte_q == HDR_SECOND) ? pos_q + 1'b1 : POS_START;
      end else if (pos_q == POS_CRC_HI) begin
        pos_q <= POS_START;
      end else begin
        pos_q <= pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) begin
      byte_q <= rx_byte_i;
    end
    if (cmd_i.step_byte) begin
      if (pos_q <= POS_AMP_LAST) begin
        crc_q <= crc_next;
      end
      if (pos_q >= POS_TURN_FIRST && pos_q <= POS_TURN_LAST) begin
        turns_q <= {turns_q[23:0], byte_q};
      end
      if (pos_q >= POS_AMP_FIRST && pos_q <= POS_AMP_LAST) begin
        amps_q <= {amps_q[7:0], byte_q};
      end
      if (pos_q == POS_CRC_LO) begin
        crc_lo_q <= byte_q;
      end
      if (pos_q == POS_CRC_HI) begin
        crc_ok_q <= ({byte_q, crc_lo_q} == crc_q);
      end
    end
  end

  // Accumulators: clear on poll, add on a good frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_sum_q <= '0;
      cur_sum_q  <= '0;
      acc_cnt_q  <= '0;
      high_cnt_q <= '0;
      low_cnt_q  <= '0;
    end else if (cmd_i.poll_start) begin
      turn_sum_q <= '0;
      cur_sum_q  <= '0;
      acc_cnt_q  <= '0;
      high_cnt_q <= '0;
      low_cnt_q  <= '0;
    end else if (cmd_i.classify && crc_ok_q) begin
      priority if (is_high) begin
        high_cnt_q <= high_cnt_q + 1'b1;
      end else if (turns_q == '0) begin
        low_cnt_q <= low_cnt_q + 1'b1;
      end else begin
        turn_sum_q <= turn_sum_q + turns_q;
        cur_sum_q  <= cur_sum_q + amps_q;
        acc_cnt_q  <= acc_cnt_q + 1'b1;
      end
    end
  end

  // Restoring divider shared by both averages
  always_ff @(posedge clk_i) begin
    if (cmd_i.poll_start) begin
      quo_q       <= stat_o.have_avg ? turn_sum_q : '0;
      rem_q       <= '0;
      div_q       <= acc_cnt_q;
      cur_snap_q  <= cur_sum_q;
      avg_turns_q <= '0;
      priority if (acc_cnt_q != '0) begin
        status_q <= ST_AVG;
      end else if (high_cnt_q != '0) begin
        status_q <= ST_HIGH;
      end else if (low_cnt_q != '0) begin
        status_q <= ST_LOW;
      end else begin
        status_q <= ST_NONE;
      end
    end else if (cmd_i.div_swap) begin
      avg_turns_q <= quo_q[15:0];
      quo_q       <= {cur_snap_q, 16'h0000};
      rem_q       <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[30:0], rem_ge};
      rem_q <= rem_ge ? rem_diff[15:0] : rem_sh[15:0];
    end
  end

  // Turn quotient high half is kept separately since the swap reuses quo_q
  logic [15:0] avg_turns_hi_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.poll_start) begin
      avg_turns_hi_q <= '0;
    end else if (cmd_i.div_swap) begin
      avg_turns_hi_q <= quo_q[31:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_turns_q  <= {avg_turns_hi_q, avg_turns_q};
      out_cur_q    <= quo_q[15:0];
      out_status_q <= status_q;
    end
  end

  assign avg_turns_o   = out_turns_q;
  assign avg_current_o = out_cur_q;
  assign status_o      = out_status_q;

endmodule

FILE: src/fspa_checker.sv
// Port-level checker for the framed sensor packet averager, bound to the top level.
module fspa_checker
  import fspa_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // A stalled result holds its valid and payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

  // Averages are zero unless the status reports averaged readings
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_AVG)) |-> (m_axis_tdata == '0))
    else $error("nonzero averages without averaged status");

  // A byte transfer keeps the input side busy in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> !s_axis_tready)
    else $error("input ready right after a byte transfer");

  // A poll end holds the input side busy right after its transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser) |=> !s_axis_tready)
    else $error("input ready right after a poll end transfer");

endmodule

bind framed_sensor_packet_averager fspa_checker u_fspa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: dv/framed_sensor_packet_averager_tb.sv
// Self-checking testbench for the framed sensor packet averager.
module framed_sensor_packet_averager_tb;
  import fspa_pkg::*;

  // Input item kinds carried on s_axis_tuser
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POLL = 1'b1;
  // Register index past the end of the map; the block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;

  localparam int SETTLE_CYCLES = 60;    // quiet time at the end of a drain
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int STALL_LIMIT   = 4000;  // cycles with no transfer anywhere before giving up
  localparam int PHASE_ITEMS   = 430;   // three random phases; with the directed tests ~1800

  typedef struct packed {
    logic [31:0] avg_turns;
    logic [15:0] avg_amps;
    logic [1:0]  status;
  } report_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic                 s_axis_tuser = OP_BYTE; // [0] opcode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [47:0]          m_axis_tdata;           // [31:0] average_full_count, [47:32] average_current
  logic [1:0]           m_axis_tuser;           // [1:0] report_status
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [15:0]          cfg_data_i = '0;

  framed_sensor_packet_averager dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor state: registers, frame hunt and accumulators as the block keeps them
  // ---------------------------------------------------------------------------
  logic [15:0] steps_reg = STEPS_RESET;
  logic [15:0] revs_reg  = REVS_RESET;
  int unsigned hunt_pos = 0;
  logic [7:0]  frame_buf [FRAME_BYTES];
  logic [31:0] turn_acc = '0;
  logic [15:0] amp_acc  = '0;
  logic [15:0] n_ok = '0, n_high = '0, n_low = '0;
  report_t     pending_reports [$];

  // Control shared between the stimulus and the result sink
  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;
  bit hold_req    = 1'b0;

  // Bookkeeping for the summary
  int errors = 0, items_sent = 0, reports_seen = 0, cfg_writes = 0, holds_done = 0;
  int frames_avg = 0, frames_high = 0, frames_low = 0, frames_bad = 0;

  function automatic logic [15:0] modbus_crc(input logic [7:0] bytes [FRAME_BYTES], input int n);
    logic [15:0] crc;
    crc = CRC_INIT;
    for (int i = 0; i < n; i++) begin
      crc ^= {8'h00, bytes[i]};
      for (int k = 0; k < 8; k++) begin
        crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  function automatic logic [31:0] turn_limit();
    return 32'(steps_reg) * 32'(revs_reg);
  endfunction

  // Check a completed frame and fold its reading into the right bucket.
  function automatic void absorb_frame();
    logic [31:0] turns;
    logic [15:0] amps;
    if ({frame_buf[10], frame_buf[9]} != modbus_crc(frame_buf, FRAME_BYTES - 2)) begin
      frames_bad++;
      return;
    end
    turns = {frame_buf[3], frame_buf[4], frame_buf[5], frame_buf[6]};
    amps  = {frame_buf[7], frame_buf[8]};
    if (turns > turn_limit() || amps > CURRENT_LIMIT) begin
      n_high++;
      frames_high++;
    end else if (turns == 32'd0) begin
      n_low++;
      frames_low++;
    end else begin
      turn_acc += turns;
      amp_acc  += amps;
      n_ok++;
      frames_avg++;
    end
  endfunction

  // Frame hunt: only 0x01 opens a frame, and a wrong second byte drops it without restarting.
  function automatic void predict_byte(input logic [7:0] b);
    if (hunt_pos == 0) begin
      if (b == HDR_FIRST) begin
        frame_buf[0] = b;
        hunt_pos = 1;
      end
    end else if (hunt_pos == 1) begin
      if (b == HDR_SECOND) begin
        frame_buf[1] = b;
        hunt_pos = 2;
      end else begin
        hunt_pos = 0;
      end
    end else begin
      frame_buf[hunt_pos] = b;
      hunt_pos++;
      if (hunt_pos == FRAME_BYTES) begin
        absorb_frame();
        hunt_pos = 0;
      end
    end
  endfunction

  // Poll end: queue the report, then clear sums and counts; the frame hunt carries on.
  function automatic void predict_poll();
    report_t r;
    r = '0;
    if (n_ok != 0) begin
      r.avg_turns = turn_acc / 32'(n_ok);
      r.avg_amps  = amp_acc / n_ok;
      r.status    = ST_AVG;
    end else if (n_high != 0) begin
      r.status = ST_HIGH;
    end else if (n_low != 0) begin
      r.status = ST_LOW;
    end else begin
      r.status = ST_NONE;
    end
    pending_reports.push_back(r);
    turn_acc = '0;
    amp_acc  = '0;
    n_ok     = '0;
    n_high   = '0;
    n_low    = '0;
  endfunction

  // ---------------------------------------------------------------------------
  // Result sink: random ready bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end else if (out_idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare every report transfer against the oldest prediction
  // ---------------------------------------------------------------------------
  report_t head_report;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      reports_seen++;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected report: actual turns %h current %h status %0d",
                 $time, m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tuser);
        errors++;
      end else begin
        head_report = pending_reports.pop_front();
        if (m_axis_tdata[31:0] !== head_report.avg_turns) begin
          $display("%0t: average_full_count mismatch: expected %h actual %h",
                   $time, head_report.avg_turns, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[47:32] !== head_report.avg_amps) begin
          $display("%0t: average_current mismatch: expected %h actual %h",
                   $time, head_report.avg_amps, m_axis_tdata[47:32]);
          errors++;
        end
        if (m_axis_tuser !== head_report.status) begin
          $display("%0t: report_status mismatch: expected %0d actual %0d",
                   $time, head_report.status, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog: abort when no transfer happens on any channel for too long.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d reports outstanding",
               $time, STALL_LIMIT, pending_reports.size());
      $display("framed_sensor_packet_averager_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one item, optionally after a short gap; predict it once the transfer happens.
  task automatic send_item(input logic op, input logic [7:0] b);
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= (op == OP_POLL) ? 8'($urandom) : b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (op == OP_POLL) begin
      predict_poll();
    end else begin
      predict_byte(b);
    end
    items_sent++;
  endtask

  // Drop valid and let the block go idle with every report delivered.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == REG_SINGLE_TURN_STEPS) begin
      steps_reg = data;
    end else if (idx == REG_MAX_REVOLUTIONS) begin
      revs_reg = data;
    end
    cfg_writes++;
  endtask

  task automatic poll();
    send_item(OP_POLL, 8'h00);
  endtask

  // Build and send one frame; spoil flips a bit past the header, and a poll may land mid-frame.
  task automatic send_frame(input logic [31:0] turns, input logic [15:0] amps,
                            input bit spoil, input bit split_poll);
    logic [7:0]  fb [FRAME_BYTES];
    logic [15:0] crc;
    int          cut;
    fb[0] = HDR_FIRST;
    fb[1] = HDR_SECOND;
    fb[2] = 8'($urandom);
    {fb[3], fb[4], fb[5], fb[6]} = turns;
    {fb[7], fb[8]} = amps;
    crc = modbus_crc(fb, FRAME_BYTES - 2);
    fb[9]  = crc[7:0];
    fb[10] = crc[15:8];
    if (spoil) begin
      cut = $urandom_range(2, FRAME_BYTES - 1);
      fb[cut] ^= 8'(1 << $urandom_range(0, 7));
    end
    cut = split_poll ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (i == cut) poll();
      send_item(OP_BYTE, fb[i]);
    end
  endtask

  task automatic send_good(input logic [31:0] turns, input logic [15:0] amps);
    send_frame(turns, amps, 1'b0, 1'b0);
  endtask

  // Turn counts hit the class boundaries of the turn limit, else mostly fall at or below it.
  function automatic logic [31:0] pick_turns();
    logic [31:0] lim;
    lim = turn_limit();
    case ($urandom_range(0, 11))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return lim;
      3:       return lim + 32'd1;
      4:       return 32'hFFFF_FFFF;
      5:       return $urandom;
      default: return $urandom_range(lim, 1);
    endcase
  endfunction

  function automatic logic [15:0] pick_amps();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return CURRENT_LIMIT;
      2:       return CURRENT_LIMIT + 16'd1;
      3:       return 16'hFFFF;
      4:       return 16'($urandom);
      default: return 16'($urandom_range(CURRENT_LIMIT, 0));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Poll with nothing collected reports status none.
  task automatic test_empty_poll();
    poll();
  endtask

  // Reset limit 4096 * 64: the limit itself is averaged, one above is high, zero is low.
  task automatic test_reset_limits();
    send_good(turn_limit(), CURRENT_LIMIT);
    send_good(32'd1, 16'd0);
    poll();
    send_good(turn_limit() + 32'd1, 16'd0);
    send_good(32'd0, 16'd0);
    poll();
    send_good(32'd5, CURRENT_LIMIT + 16'd1);
    poll();
    send_good(32'd0, CURRENT_LIMIT);
    poll();
  endtask

  // Hunt through noise, a wrong second byte, and a second 0x01 that must not restart a frame.
  task automatic test_frame_hunt();
    send_item(OP_BYTE, 8'h55);
    send_item(OP_BYTE, HDR_SECOND);
    send_item(OP_BYTE, HDR_FIRST);
    send_item(OP_BYTE, 8'h07);
    send_item(OP_BYTE, HDR_SECOND);
    send_item(OP_BYTE, HDR_FIRST);
    send_item(OP_BYTE, HDR_FIRST);
    send_good(32'd1000, 16'd10);
    poll();
  endtask

  // A frame with a bad CRC changes nothing.
  task automatic test_bad_crc();
    send_frame(32'd77, 16'd7, 1'b1, 1'b0);
    poll();
  endtask

  // Frame position survives a poll end: the frame lands in the next interval.
  task automatic test_frame_across_poll();
    send_frame(32'd4242, 16'd42, 1'b0, 1'b1);
    poll();
  endtask

  // Walk the registers through their extremes, including an ignored index.
  task automatic test_register_extremes();
    write_reg(REG_SINGLE_TURN_STEPS, 16'd1);
    write_reg(REG_MAX_REVOLUTIONS, 16'd1);
    send_good(32'd1, 16'd1);
    send_good(32'd2, 16'd1);
    poll();
    write_reg(REG_SINGLE_TURN_STEPS, 16'hFFFF);
    write_reg(REG_MAX_REVOLUTIONS, 16'hFFFF);
    send_good(32'hFFFE_0001, 16'd0);
    send_good(32'hFFFF_FFFF, 16'd0);
    poll();
    write_reg(REG_UNUSED, 16'd1);
    send_good(32'hFFFE_0001, 16'd3);
    poll();
  endtask

  // Push both sums past their width before one poll.
  task automatic test_sum_wrap();
    repeat (25) send_good($urandom_range(32'hFFFE_0001, 32'hC000_0000), CURRENT_LIMIT);
    poll();
  endtask

  // Hold the receiver off while polls keep coming, so the block backs up into its input.
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (6) begin
      send_good(pick_turns(), pick_amps());
      poll();
      poll();
    end
    drain();
  endtask

  // Pause the sender until every report is in, then pick up again.
  task automatic test_sender_pause();
    send_good(pick_turns(), pick_amps());
    poll();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_reports.size() != 0) @(posedge clk_i);
    send_good(pick_turns(), pick_amps());
    poll();
  endtask

  // Mostly well-formed frames with random content, with noise, broken headers and spoiled CRCs.
  task automatic run_random(input int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 3))
              0:       send_item(OP_BYTE, HDR_FIRST);
              1:       send_item(OP_BYTE, HDR_SECOND);
              default: send_item(OP_BYTE, 8'($urandom));
            endcase
          end
        end
        2: begin
          send_item(OP_BYTE, HDR_FIRST);
          send_item(OP_BYTE, ($urandom_range(0, 1) != 0) ? HDR_FIRST : 8'($urandom));
        end
        3: begin
          // truncated frame: the next bytes get swallowed as its payload
          send_item(OP_BYTE, HDR_FIRST);
          send_item(OP_BYTE, HDR_SECOND);
          repeat ($urandom_range(1, 8)) send_item(OP_BYTE, 8'($urandom));
        end
        4:          send_frame(pick_turns(), pick_amps(), 1'b1, 1'b0);
        5, 6, 7, 8: poll();
        default:    send_frame(pick_turns(), pick_amps(), 1'b0, $urandom_range(0, 15) == 0);
      endcase
    end
  endtask

  task automatic test_random();
    // small limits, idling on both sides
    write_reg(REG_SINGLE_TURN_STEPS, 16'($urandom_range(64, 1)));
    write_reg(REG_MAX_REVOLUTIONS, 16'($urandom_range(16, 1)));
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    run_random(PHASE_ITEMS);
    // full-range limits, sender runs without gaps
    write_reg(REG_SINGLE_TURN_STEPS, 16'($urandom_range(16'hFFFF, 1)));
    write_reg(REG_MAX_REVOLUTIONS, 16'($urandom_range(16'hFFFF, 1)));
    in_idle_on  = 1'b0;
    out_idle_on = 1'b1;
    run_random(PHASE_ITEMS);
    // back to the reset limits, no idling at all
    write_reg(REG_SINGLE_TURN_STEPS, STEPS_RESET);
    write_reg(REG_MAX_REVOLUTIONS, REVS_RESET);
    out_idle_on = 1'b0;
    run_random(PHASE_ITEMS);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_poll();
    test_reset_limits();
    test_frame_hunt();
    test_bad_crc();
    test_frame_across_poll();
    test_register_extremes();
    test_sum_wrap();
    test_backpressure();
    test_sender_pause();
    test_random();

    drain();
    $display("Sent %0d items, checked %0d reports, made %0d register writes, %0d long holds.",
             items_sent, reports_seen, cfg_writes, holds_done);
    $display("Frames: %0d averaged, %0d high, %0d low, %0d with bad CRC; %0d mismatches.",
             frames_avg, frames_high, frames_low, frames_bad, errors);
    if (errors == 0) begin
      $display("framed_sensor_packet_averager_tb: PASS");
    end else begin
      $display("framed_sensor_packet_averager_tb: FAIL");
    end
    $finish;
  end

endmodule
